@@ src/smlr_pkg.sv @@
// Shared types and constants for the stereo mix linear resampler.
// Has no dependencies; every other source file imports it.
package smlr_pkg;

    // Fixed field widths of the sample stream.
    localparam int SAMPLE_BITS     = 16;
    localparam int FRAME_BITS      = 13;
    localparam int COUNT_BITS      = 14;
    localparam int STEP_BITS       = 20;
    localparam int SHIFT_BITS      = 3;
    localparam int MAX_RESULTS     = 64;
    localparam int RESULT_CNT_BITS = 7;

    // Configuration port layout.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 20;

    // Frame queue between the mixer and the interpolator.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // Register values after reset.
    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET  = 20'd15046;
    localparam logic [COUNT_BITS-1:0] OUT_FRAMES_RESET  = 14'd2230;
    localparam logic [SHIFT_BITS-1:0] MUSIC_SHIFT_RESET = 3'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_OUT_FRAMES  = 2'd1,
        CFG_MUSIC_SHIFT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        sample_t fx_left;
        sample_t fx_right;
        sample_t music_left;
        sample_t music_right;
        logic    block_last;
    } in_item_t;

    typedef struct packed {
        sample_t out_left;
        sample_t out_right;
        logic    run_end;
        logic    block_end;
    } out_item_t;

    // Mixed frame as it travels through the queue.
    typedef struct packed {
        sample_t mixed_left;
        sample_t mixed_right;
        logic    last;
    } frame_t;

    // Current register settings.
    typedef struct packed {
        logic [STEP_BITS-1:0]  phase_step;
        logic [COUNT_BITS-1:0] out_frames;
        logic [SHIFT_BITS-1:0] music_shift;
    } cfg_t;

endpackage

@@ src/smlr_front.sv @@
// Front end: mixes music into effects with saturation and pushes the frame.
// Depends on smlr_pkg.
module smlr_front (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  smlr_pkg::in_item_t           in_data,
    input  logic [smlr_pkg::SHIFT_BITS-1:0] music_shift,
    input  logic                         queue_full,
    output logic                         push,
    output smlr_pkg::frame_t             push_frame
);
    import smlr_pkg::*;

    localparam int MIX_BITS = SAMPLE_BITS + 9;
    localparam logic signed [MIX_BITS-1:0] SAT_HI = MIX_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [MIX_BITS-1:0] SAT_LO = -SAT_HI - MIX_BITS'(1);

    // Shift the music sample, add the effect and clamp to the sample range.
    function automatic sample_t mix(input sample_t fx, input sample_t mu,
                                    input logic [SHIFT_BITS-1:0] shift);
        logic signed [MIX_BITS-1:0] sum;
        sum = MIX_BITS'(fx) + (MIX_BITS'(mu) <<< shift);
        if (sum > SAT_HI)
        begin
            return SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (sum < SAT_LO)
        begin
            return SAT_LO[SAMPLE_BITS-1:0];
        end
        return sum[SAMPLE_BITS-1:0];
    endfunction

    // A transfer completes whenever the queue has room.
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_frame.mixed_left  = mix(in_data.fx_left, in_data.music_left, music_shift);
        push_frame.mixed_right = mix(in_data.fx_right, in_data.music_right, music_shift);
        push_frame.last        = in_data.block_last;
    end

endmodule

@@ src/smlr_queue.sv @@
// Short frame queue that decouples the mixer from the interpolator.
// Depends on smlr_pkg.
module smlr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  smlr_pkg::frame_t push_frame,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output smlr_pkg::frame_t head_frame
);
    import smlr_pkg::*;

    frame_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_frame = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Frame storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

@@ src/smlr_back.sv @@
// Back end: interpolates each frame's output positions, one a cycle unless output stalls.
// Depends on smlr_pkg.
module smlr_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smlr_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  smlr_pkg::frame_t    head_frame,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output smlr_pkg::out_item_t out_data
);
    import smlr_pkg::*;

    localparam int PHASE_BITS = FRAME_BITS + FRAC_BITS;
    localparam int PROD_BITS  = FRAC_BITS + SAMPLE_BITS + 2;
    localparam logic [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'((64'd1 << FRAC_BITS) - 64'd1);

    sample_t                    held_left_reg,  held_left_next;
    sample_t                    held_right_reg, held_right_next;
    logic                       held_valid_reg, held_valid_next;
    logic [FRAME_BITS-1:0]      frame_index_reg, frame_index_next;
    logic [COUNT_BITS-1:0]      output_count_reg, output_count_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic [RESULT_CNT_BITS-1:0] n_reg, n_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;

    logic                       slot_free;
    logic                       advance;
    logic                       room;
    logic                       do_interp;
    logic                       do_repeat;
    logic                       emit;
    logic                       more;
    logic [PHASE_BITS:0]        phase_sum;
    logic [PHASE_BITS-1:0]      phase_adv;
    logic [COUNT_BITS-1:0]      count_inc;
    logic [RESULT_CNT_BITS-1:0] n_inc;
    logic [FRAC_BITS-1:0]       frac;
    sample_t                    interp_left;
    sample_t                    interp_right;

    // y1 + frac * (y2 - y1) / 2^FRAC_BITS, with the quotient truncated toward zero.
    function automatic sample_t lerp(input sample_t y1, input sample_t y2,
                                     input logic [FRAC_BITS-1:0] f);
        logic signed [SAMPLE_BITS:0]   diff;
        logic signed [PROD_BITS-1:0]   prod;
        logic signed [PROD_BITS-1:0]   quot;
        diff = (SAMPLE_BITS + 1)'(y2) - (SAMPLE_BITS + 1)'(y1);
        prod = PROD_BITS'($signed({1'b0, f}) * diff);
        if (prod < 0)
        begin
            prod = prod + $signed(ROUND_BIAS);
        end
        quot = prod >>> FRAC_BITS;
        return y1 + quot[SAMPLE_BITS-1:0];
    endfunction

    // Emission decision for the frame at the head of the queue.
    always_comb
    begin
        slot_free = !out_valid_reg || out_ready;
        advance   = head_valid && slot_free;
        room      = (n_reg < RESULT_CNT_BITS'(MAX_RESULTS)) &&
                    (output_count_reg < cfg.out_frames);
        do_interp = held_valid_reg && room &&
                    (phase_reg[PHASE_BITS-1:FRAC_BITS] < frame_index_reg);
        do_repeat = !do_interp && head_frame.last && room;
        emit      = do_interp || do_repeat;

        phase_sum = {1'b0, phase_reg} + (PHASE_BITS + 1)'(cfg.phase_step);
        phase_adv = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
        count_inc = output_count_reg + 1'b1;
        n_inc     = n_reg + 1'b1;

        // Whether another result of this frame follows the one emitted now.
        more = (n_inc < RESULT_CNT_BITS'(MAX_RESULTS)) &&
               (count_inc < cfg.out_frames) &&
               (head_frame.last ||
                (held_valid_reg && (phase_adv[PHASE_BITS-1:FRAC_BITS] < frame_index_reg)));

        pop = advance && (!emit || !more);
    end

    // Interpolated sample pair; right copies left when the held frame is centered.
    always_comb
    begin
        frac         = phase_reg[FRAC_BITS-1:0];
        interp_left  = lerp(held_left_reg, head_frame.mixed_left, frac);
        interp_right = (held_left_reg == held_right_reg) ? interp_left :
                       lerp(held_right_reg, head_frame.mixed_right, frac);
    end

    // Next state of the interpolator and the output register.
    always_comb
    begin
        held_left_next    = held_left_reg;
        held_right_next   = held_right_reg;
        held_valid_next   = held_valid_reg;
        frame_index_next  = frame_index_reg;
        output_count_next = output_count_reg;
        phase_next        = phase_reg;
        n_next            = n_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;

        if (slot_free)
        begin
            out_valid_next = advance && emit;
        end

        if (advance && emit)
        begin
            output_count_next       = count_inc;
            phase_next              = phase_adv;
            n_next                  = n_inc;
            out_data_next.out_left  = do_interp ? interp_left : head_frame.mixed_left;
            out_data_next.out_right = do_interp ? interp_right : head_frame.mixed_right;
            out_data_next.run_end   = !more;
            out_data_next.block_end = (count_inc == cfg.out_frames) ||
                                      (head_frame.last && !more);
        end

        if (pop)
        begin
            n_next = '0;
            if (head_frame.last)
            begin
                held_left_next    = '0;
                held_right_next   = '0;
                held_valid_next   = 1'b0;
                frame_index_next  = '0;
                output_count_next = '0;
                phase_next        = '0;
            end
            else
            begin
                held_left_next  = head_frame.mixed_left;
                held_right_next = head_frame.mixed_right;
                held_valid_next = 1'b1;
                if (frame_index_reg != '1)
                begin
                    frame_index_next = frame_index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_left_reg    <= '0;
            held_right_reg   <= '0;
            held_valid_reg   <= 1'b0;
            frame_index_reg  <= '0;
            output_count_reg <= '0;
            phase_reg        <= '0;
            n_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            held_left_reg    <= held_left_next;
            held_right_reg   <= held_right_next;
            held_valid_reg   <= held_valid_next;
            frame_index_reg  <= frame_index_next;
            output_count_reg <= output_count_next;
            phase_reg        <= phase_next;
            n_reg            <= n_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/stereo_mix_linear_resampler.sv @@
// Top level of the stereo mix linear resampler: configuration registers and wiring.
// Depends on smlr_pkg, smlr_front, smlr_queue and smlr_back.
//
// Usage:
//   Input frames (effects and music, left and right, plus block_last) arrive on the
//   in_valid/in_ready channel. Each is mixed at once and stored in a four-frame queue.
//   Results leave on the out_valid/out_ready channel as interpolated stereo frames,
//   with run_end on the last result caused by a frame and block_end on the final
//   result of a block.
//   The interpolator handles one frame per cycle when the frame causes no result,
//   and otherwise emits one result per cycle, both while the output is not stalled.
//   A frame causes at most 64 results.
//   The input accepts new frames while the queue has room, also while results wait.
//   When the receiver stalls, the output register holds its result, the interpolator
//   stops, and the input stalls only once the queue is full.
//   Reset clears the queue, the interpolation state and the output valid flag, and
//   loads the registers with phase_step 15046, out_frames 2230 and music_shift 2.
//   The user must write the registers through cfg_write/cfg_index/cfg_data only
//   while the block is idle; the block itself does not enforce this.
module stereo_mix_linear_resampler #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  smlr_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output smlr_pkg::out_item_t                  out_data,
    input  logic                                 cfg_write,
    input  logic [smlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [smlr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import smlr_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push;
    frame_t push_frame;
    logic   queue_full;
    logic   pop;
    logic   head_valid;
    frame_t head_frame;

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PHASE_STEP:  cfg_next.phase_step  = cfg_data[STEP_BITS-1:0];
                CFG_OUT_FRAMES:  cfg_next.out_frames  = cfg_data[COUNT_BITS-1:0];
                CFG_MUSIC_SHIFT: cfg_next.music_shift = cfg_data[SHIFT_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step  <= PHASE_STEP_RESET;
            cfg_reg.out_frames  <= OUT_FRAMES_RESET;
            cfg_reg.music_shift <= MUSIC_SHIFT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    smlr_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .music_shift (cfg_reg.music_shift),
        .queue_full  (queue_full),
        .push        (push),
        .push_frame  (push_frame)
    );

    smlr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    smlr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for stereo_mix_linear_resampler: a directed table of frames
// followed by random blocks under several register settings.
// Depends on smlr_pkg and the stereo_mix_linear_resampler RTL.
`timescale 1ns / 100ps

module tb;
    import smlr_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int PHASE_BITS    = FRAME_BITS + FRAC_BITS;
    localparam int MAX_REPORTS   = 10;
    localparam int GAP_MAX       = 13;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_ITEMS   = 30;
    localparam int RANDOM_PHASES = 6;

    localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
    localparam sample_t S_MAX = 16'sh7FFF;
    localparam sample_t S_MIN = 16'sh8000;

    // Register write masks, one bit per register index.
    localparam logic [2:0] WR_NONE   = 3'b000;
    localparam logic [2:0] WR_STEP   = 3'b001;
    localparam logic [2:0] WR_FRAMES = 3'b010;
    localparam logic [2:0] WR_SHIFT  = 3'b100;
    localparam logic [2:0] WR_ALL    = 3'b111;

    // One row of the directed stimulus; typed_n < 0 means the predictor decides.
    typedef struct {
        logic [2:0] wr_mask;
        cfg_t       regs;
        in_item_t   frame;
        int         typed_n;
        out_item_t  typed_out;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    in_item_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_PHASE_STEP;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Register copies as seen by the resampler.
    logic [STEP_BITS-1:0]  cur_step   = PHASE_STEP_RESET;
    logic [COUNT_BITS-1:0] cur_frames = OUT_FRAMES_RESET;
    logic [SHIFT_BITS-1:0] cur_shift  = MUSIC_SHIFT_RESET;

    // Interpolation state of the behavioral resampler.
    sample_t               held_l     = '0;
    sample_t               held_r     = '0;
    bit                    held_ok    = 1'b0;
    logic [FRAME_BITS-1:0] frame_idx  = '0;
    logic [COUNT_BITS-1:0] out_count  = '0;
    logic [PHASE_BITS-1:0] src_phase  = '0;

    out_item_t frame_outputs[$];
    out_item_t expected_out[$];
    stim_row_t stim_rows[$];
    int        mismatch_count = 0;
    bit        in_gaps_on     = 1'b1;
    bit        out_stalls_on  = 1'b1;

    stereo_mix_linear_resampler #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Effects plus shifted music, saturated to the sample range.
    function automatic sample_t mix_sample(sample_t fx, sample_t music);
        int sum;
        sum = int'(fx) + (int'(music) <<< cur_shift);
        if (sum > int'(S_MAX))
            sum = int'(S_MAX);
        if (sum < int'(S_MIN))
            sum = int'(S_MIN);
        return sample_t'(sum);
    endfunction

    // y1 + frac * (y2 - y1) / 2^FRAC_BITS, the quotient truncated toward zero.
    function automatic sample_t lerp_sample(sample_t y1, sample_t y2,
                                            logic [FRAC_BITS-1:0] frac);
        longint prod;
        prod = longint'(frac) * (longint'(y2) - longint'(y1));
        return sample_t'(longint'(y1) + prod / (longint'(1) <<< FRAC_BITS));
    endfunction

    // One output frame: bump the count, flag the block end, advance the phase.
    function automatic void emit_output(sample_t l, sample_t r);
        out_item_t          res;
        logic [PHASE_BITS:0] next_phase;
        out_count     = out_count + 1'b1;
        res.out_left  = l;
        res.out_right = r;
        res.run_end   = 1'b0;
        res.block_end = (out_count == cur_frames);
        frame_outputs.push_back(res);
        next_phase = {1'b0, src_phase} + (PHASE_BITS + 1)'(cur_step);
        if (next_phase > {1'b0, PHASE_MAX})
            src_phase = PHASE_MAX;
        else
            src_phase = next_phase[PHASE_BITS-1:0];
    endfunction

    // Works out every output frame that one input frame causes.
    function automatic void predict_frame(in_item_t frame);
        sample_t   mix_l;
        sample_t   mix_r;
        sample_t   l;
        sample_t   r;
        out_item_t tail;
        mix_l = mix_sample(frame.fx_left, frame.music_left);
        mix_r = mix_sample(frame.fx_right, frame.music_right);
        frame_outputs.delete();

        // Outputs whose source lies between the held frame and this one.
        if (held_ok)
        begin
            while (frame_outputs.size() < MAX_RESULTS && out_count < cur_frames &&
                   src_phase[PHASE_BITS-1:FRAC_BITS] < frame_idx)
            begin
                l = lerp_sample(held_l, mix_l, src_phase[FRAC_BITS-1:0]);
                if (held_l == held_r)
                    r = l;
                else
                    r = lerp_sample(held_r, mix_r, src_phase[FRAC_BITS-1:0]);
                emit_output(l, r);
            end
        end

        if (frame.block_last)
        begin
            // Fill the rest of the block with the last frame, then start over.
            while (frame_outputs.size() < MAX_RESULTS && out_count < cur_frames)
                emit_output(mix_l, mix_r);
            if (frame_outputs.size() > 0)
            begin
                tail = frame_outputs[frame_outputs.size() - 1];
                tail.block_end = 1'b1;
                frame_outputs[frame_outputs.size() - 1] = tail;
            end
            held_l    = '0;
            held_r    = '0;
            held_ok   = 1'b0;
            frame_idx = '0;
            out_count = '0;
            src_phase = '0;
        end
        else
        begin
            held_l  = mix_l;
            held_r  = mix_r;
            held_ok = 1'b1;
            if (frame_idx != FRAME_MAX)
                frame_idx = frame_idx + 1'b1;
        end

        if (frame_outputs.size() > 0)
        begin
            tail = frame_outputs[frame_outputs.size() - 1];
            tail.run_end = 1'b1;
            frame_outputs[frame_outputs.size() - 1] = tail;
        end
    endfunction

    // Compares one output transfer with the oldest expected frame.
    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (expected_out.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: unexpected output L %0d R %0d run_end %0b block_end %0b",
                         $time, got.out_left, got.out_right, got.run_end, got.block_end);
            return;
        end
        want = expected_out.pop_front();
        if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
            got.run_end !== want.run_end || got.block_end !== want.block_end)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: mismatch: expected L %0d R %0d run_end %0b block_end %0b, %s",
                         $time, want.out_left, want.out_right, want.run_end,
                         want.block_end,
                         $sformatf("got L %0d R %0d run_end %0b block_end %0b",
                                   got.out_left, got.out_right, got.run_end,
                                   got.block_end));
        end
    endfunction

    function automatic void add_row(logic [2:0] wr_mask, cfg_t regs, in_item_t frame,
                                    int typed_n, out_item_t typed_out);
        stim_row_t row;
        row.wr_mask   = wr_mask;
        row.regs      = regs;
        row.frame     = frame;
        row.typed_n   = typed_n;
        row.typed_out = typed_out;
        stim_rows.push_back(row);
    endfunction

    // Sample values with extra weight on full scale, zero and small values.
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return sample_t'($urandom_range(0, 15) - 8);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // A random frame; one in four has equal left and right channels.
    function automatic in_item_t random_frame(logic closing);
        in_item_t frame;
        frame.fx_left    = rand_sample();
        frame.music_left = rand_sample();
        if ($urandom_range(0, 3) == 0)
        begin
            frame.fx_right    = frame.fx_left;
            frame.music_right = frame.music_left;
        end
        else
        begin
            frame.fx_right    = rand_sample();
            frame.music_right = rand_sample();
        end
        frame.block_last = closing;
        return frame;
    endfunction

    // Offers one frame after a random gap and records what its transfer causes.
    task automatic send_frame(in_item_t frame, int typed_n, out_item_t typed_out);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_gaps_on = !in_gaps_on;
        gap = in_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_frame(frame);
        if (typed_n < 0)
        begin
            foreach (frame_outputs[k])
                expected_out.push_back(frame_outputs[k]);
        end
        else if (typed_n == 1)
            expected_out.push_back(typed_out);
    endtask

    // Waits until every expected frame is out and the frame queue has drained.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the selected registers back to back, one per clock.
    task automatic program_regs(logic [2:0] wr_mask, cfg_t regs);
        if (wr_mask[CFG_PHASE_STEP])
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_PHASE_STEP;
            cfg_data  <= regs.phase_step;
            @(posedge clk);
            cur_step = regs.phase_step;
        end
        if (wr_mask[CFG_OUT_FRAMES])
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_OUT_FRAMES;
            cfg_data  <= CFG_DATA_BITS'(regs.out_frames);
            @(posedge clk);
            cur_frames = regs.out_frames;
        end
        if (wr_mask[CFG_MUSIC_SHIFT])
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_MUSIC_SHIFT;
            cfg_data  <= CFG_DATA_BITS'(regs.music_shift);
            @(posedge clk);
            cur_shift = regs.music_shift;
        end
        cfg_write <= 1'b0;
    endtask

    // Output side: random stalls, then take and check the next transfer.
    initial
    begin : output_side
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_stalls_on = !out_stalls_on;
            stall = out_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_result(out_data);
        end
    end

    // Run time limit.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        cfg_t      regs;
        int        sent;
        int        run_len;
        bit        noisy;
        logic      closing;

        // First frame of a fresh block yields nothing.
        add_row(WR_NONE, '0, in_item_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 0, '0);
        // Full-scale effects and music saturate high on the left and low on the right.
        add_row(WR_NONE, '0, in_item_t'{S_MAX, S_MIN, S_MAX, S_MIN, 1'b0}, -1, '0);
        // Closing frame: due outputs, then the last frame repeated up to the cap.
        add_row(WR_NONE, '0, in_item_t'{16'sd1, -16'sd1, -16'sd1, 16'sd1, 1'b1}, -1, '0);
        // Held frame with equal channels: the right output copies the left.
        add_row(WR_NONE, '0, in_item_t'{16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b0}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{-16'sd20000, 16'sd20000, 16'sd0, 16'sd0, 1'b0},
                -1, '0);
        // Largest music shift.
        add_row(WR_SHIFT, cfg_t'{20'd15046, 14'd2230, 3'd7},
                in_item_t'{S_MIN, 16'sd0, S_MIN, 16'sd1, 1'b0}, -1, '0);
        // Zero step: every output sits at position zero, capped per frame.
        add_row(WR_STEP, cfg_t'{20'd0, 14'd2230, 3'd7},
                in_item_t'{16'sd12345, -16'sd12345, -16'sd7, 16'sd7, 1'b0}, -1, '0);
        add_row(WR_NONE, '0, in_item_t'{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0}, -1, '0);
        add_row(WR_NONE, '0, in_item_t'{16'sd5000, -16'sd5000, 16'sd0, 16'sd0, 1'b1},
                -1, '0);
        // Largest step: one output at fraction zero gives the held frame itself.
        add_row(WR_ALL, cfg_t'{20'd1048575, 14'd8192, 3'd0},
                in_item_t'{S_MIN, S_MAX, 16'sd0, 16'sd0, 1'b0}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
                1, out_item_t'{S_MIN, S_MAX, 1'b1, 1'b0});
        add_row(WR_NONE, '0, in_item_t'{16'sd7, -16'sd7, 16'sd0, 16'sd0, 1'b1}, -1, '0);
        // One output per block: a lone closing frame gives its own mix.
        add_row(WR_STEP | WR_FRAMES, cfg_t'{20'd15046, 14'd1, 3'd0},
                in_item_t'{S_MIN, S_MAX, S_MAX, S_MAX, 1'b1},
                1, out_item_t'{-16'sd1, S_MAX, 1'b1, 1'b1});
        add_row(WR_NONE, '0, in_item_t'{16'sd300, -16'sd300, 16'sd0, 16'sd0, 1'b0}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{-16'sd5, 16'sd5, 16'sd0, 16'sd0, 1'b0},
                1, out_item_t'{16'sd300, -16'sd300, 1'b1, 1'b1});
        // Output limit reached: nothing more until and including the closing frame.
        add_row(WR_NONE, '0, in_item_t'{16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{16'sd9, 16'sd9, 16'sd9, 16'sd9, 1'b1}, 0, '0);
        // Zero output frames: no results at all.
        add_row(WR_FRAMES, cfg_t'{20'd15046, 14'd0, 3'd0},
                in_item_t'{S_MAX, S_MAX, S_MAX, S_MAX, 1'b0}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{S_MIN, S_MIN, S_MIN, S_MIN, 1'b0}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{S_MIN, S_MAX, S_MIN, S_MAX, 1'b1}, 0, '0);
        add_row(WR_NONE, '0, in_item_t'{S_MAX, S_MIN, S_MAX, S_MIN, 1'b1}, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames.
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.wr_mask != WR_NONE)
            begin
                settle();
                program_regs(row.wr_mask, row.regs);
            end
            send_frame(row.frame, row.typed_n, row.typed_out);
        end

        // Random blocks under several settings; a few runs have random block ends.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: regs = cfg_t'{PHASE_STEP_RESET, OUT_FRAMES_RESET, MUSIC_SHIFT_RESET};
                1: regs = cfg_t'{20'd1, 14'($urandom_range(64, 300)),
                                 3'($urandom_range(0, 7))};
                2: regs = cfg_t'{20'd65536, 14'd8192, 3'd7};
                3: regs = cfg_t'{20'd1048575, 14'd8192, 3'd0};
                4: regs = cfg_t'{20'($urandom_range(4096, 262143)),
                                 14'($urandom_range(1, 8192)), 3'($urandom_range(0, 7))};
                default: regs = cfg_t'{20'($urandom_range(1, 1048575)),
                                       14'($urandom_range(1, 400)),
                                       3'($urandom_range(0, 7))};
            endcase
            settle();
            program_regs(WR_ALL, regs);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len = $urandom_range(1, 24);
                noisy   = ($urandom_range(0, 7) == 0);
                for (int j = 0; j < run_len && sent < PHASE_ITEMS; j++)
                begin
                    closing = noisy ? 1'($urandom_range(0, 1)) : (j == run_len - 1);
                    send_frame(random_frame(closing), -1, '0);
                    sent++;
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
